// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the console bus map decoder RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/cbmm_pkg.sv =====
// Package for the console bus memory map decoder: widths, target and
// register codes, access costs and the decode result type. No dependencies.
package cbmm_pkg;

    localparam int ADDR_W          = 24;
    localparam int OFFSET_W        = 22;
    localparam int MASK_W          = 13;
    localparam int CYCLES_W        = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 13;

    localparam int WORK_RAM_BYTES  = 131072;
    localparam int WORK_RAM_AW     = 17;
    localparam int SAVE_RAM_BYTES_DEF = 8192;
    localparam int ROM_ADDR_BITS_DEF  = 22;

    typedef logic [2:0] target_t;

    localparam target_t TGT_WORK_RAM = 3'd0;
    localparam target_t TGT_SAVE_RAM = 3'd1;
    localparam target_t TGT_ROM      = 3'd2;
    localparam target_t TGT_PPU      = 3'd3;
    localparam target_t TGT_IO       = 3'd4;
    localparam target_t TGT_JOYPAD   = 3'd5;
    localparam target_t TGT_NONE     = 3'd6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ROM_LAYOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_RAM_MASK  = 1'd1;

    localparam logic [CYCLES_W-1:0] CYC_FAST = 4'd6;
    localparam logic [CYCLES_W-1:0] CYC_SLOW = 4'd8;

    localparam logic [7:0] WRAM_RESET_BYTE = 8'h55;
    localparam logic [7:0] SRAM_RESET_BYTE = 8'h00;
    localparam logic [7:0] OPEN_BUS_FF     = 8'hFF;
    localparam logic [7:0] OPEN_BUS_00     = 8'h00;

    typedef struct packed {
        target_t               target;
        logic [OFFSET_W-1:0]   offset;
        logic [7:0]            konst;
        logic [CYCLES_W-1:0]   cycles;
    } dec_t;

endpackage

// ===== hdl/cbmm_req_if.sv =====
// Request channel of the bus map decoder: one CPU bus access per transfer.
// Depends on cbmm_pkg.
interface cbmm_req_if;
    import cbmm_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] bus_address;
    logic [7:0]        write_byte;

    modport source (output valid, output operation, output bus_address,
                    output write_byte, input ready);
    modport sink   (input valid, input operation, input bus_address,
                    input write_byte, output ready);
endinterface

// ===== hdl/cbmm_rsp_if.sv =====
// Result channel of the bus map decoder: one decoded access per transfer.
// Depends on cbmm_pkg.
interface cbmm_rsp_if;
    import cbmm_pkg::*;

    logic                valid;
    logic                ready;
    target_t             target;
    logic [OFFSET_W-1:0] local_offset;
    logic [7:0]          read_byte;
    logic [CYCLES_W-1:0] access_cycles;

    modport source (output valid, output target, output local_offset,
                    output read_byte, output access_cycles, input ready);
    modport sink   (input valid, input target, input local_offset,
                    input read_byte, input access_cycles, output ready);
endinterface

// ===== hdl/cbmm_cfg_if.sv =====
// Configuration write channel of the bus map decoder.
// Depends on cbmm_pkg.
interface cbmm_cfg_if;
    import cbmm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cbmm_decode.sv =====
// Address decode of one CPU bus access under the low-ROM or high-ROM map.
// Purely combinational; depends on cbmm_pkg.
module cbmm_decode #(
    parameter int ROM_ADDR_BITS = cbmm_pkg::ROM_ADDR_BITS_DEF
) (
    input  logic                          operation,
    input  logic [cbmm_pkg::ADDR_W-1:0]   bus_address,
    input  logic                          low_rom_layout,
    input  logic [cbmm_pkg::MASK_W-1:0]   save_ram_mask,
    output cbmm_pkg::dec_t                dec
);
    import cbmm_pkg::*;

    localparam logic [ADDR_W-1:0] ROM_MASK =
        ADDR_W'((33'd1 << ROM_ADDR_BITS) - 33'd1);

    logic [7:0]          bank;
    logic [2:0]          slot;
    logic [3:0]          nib;
    logic                sys;
    logic                sys_area;
    logic                wr;
    logic [ADDR_W-1:0]   rom_lo;
    logic [ADDR_W-1:0]   rom_hi;
    logic [OFFSET_W-1:0] low16;
    logic [OFFSET_W-1:0] sram_masked;
    dec_t                rest;
    dec_t                pick;

    assign bank     = bus_address[23:16];
    assign slot     = bus_address[15:13];
    assign nib      = bus_address[15:12];
    assign sys      = !bank[6];
    assign sys_area = sys && (slot != 3'd0) && !slot[2];
    assign wr       = (operation == OP_WRITE);
    assign rom_lo   = {2'b00, bank[6:0], bus_address[14:0]} & ROM_MASK;
    assign rom_hi   = bus_address & ROM_MASK;
    assign low16    = {6'd0, bus_address[15:0]};
    assign sram_masked = {9'd0, bus_address[12:0] & save_ram_mask};

    // Accesses that fall outside the directly mapped pages.
    always_comb
    begin
        rest = '{TGT_NONE, '0, OPEN_BUS_FF, CYC_SLOW};
        if (sys) begin
            case (nib)
                4'h2: rest = '{TGT_PPU, low16, OPEN_BUS_00, CYC_SLOW};
                4'h4:
                begin
                    if (bus_address[11:9] == 3'b001)
                        rest = '{TGT_IO, low16, OPEN_BUS_00, CYC_SLOW};
                    else if (bus_address[15:1] == 15'h200B)
                        rest = '{TGT_JOYPAD, low16, OPEN_BUS_00, CYC_SLOW};
                    else
                        rest = '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW};
                end
                4'h6, 4'h7:
                begin
                    if (!low_rom_layout)
                        rest = '{TGT_SAVE_RAM, sram_masked, OPEN_BUS_00, CYC_SLOW};
                end
                default: rest = '{TGT_NONE, '0, OPEN_BUS_FF, CYC_SLOW};
            endcase
        end else if (bank >= 8'hD0 && bank <= 8'hFE) begin
            rest = '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW};
        end else if (bank == 8'h70) begin
            if (wr || save_ram_mask != '0)
                rest = '{TGT_SAVE_RAM, sram_masked, OPEN_BUS_00, CYC_SLOW};
            else
                rest = '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW};
        end else if (bank == 8'h60) begin
            rest = '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW};
        end
    end

    always_comb
    begin
        if (bank == 8'h7E || bank == 8'h7F)
            pick = '{TGT_WORK_RAM, {5'd0, bank[0], bus_address[15:0]}, OPEN_BUS_00, CYC_SLOW};
        else if (sys && slot == 3'd0)
            pick = '{TGT_WORK_RAM, {9'd0, bus_address[12:0]}, OPEN_BUS_00, CYC_SLOW};
        else if (low_rom_layout) begin
            if (slot[2] && bank[6:0] < 7'h60)
                pick = wr ? '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW}
                          : '{TGT_ROM, rom_lo[OFFSET_W-1:0], OPEN_BUS_00, CYC_SLOW};
            else
                pick = rest;
        end else if (bank == 8'h70 || bank == 8'h71)
            pick = '{TGT_SAVE_RAM, {9'd0, bus_address[12:0]}, OPEN_BUS_00, CYC_SLOW};
        else if (sys_area)
            pick = rest;
        else
            pick = wr ? '{TGT_NONE, '0, OPEN_BUS_00, CYC_SLOW}
                      : '{TGT_ROM, rom_hi[OFFSET_W-1:0], OPEN_BUS_00, CYC_SLOW};

        dec        = pick;
        // Writes always return 0x00 as their constant.
        if (wr)
            dec.konst = OPEN_BUS_00;
        dec.cycles = sys_area ? CYC_FAST : CYC_SLOW;
    end

endmodule

// ===== hdl/console_bus_memory_map_decoder.sv =====
// Console bus memory map decoder, top level. Holds work RAM and save RAM.
// Depends on cbmm_pkg, the three channel interfaces, cbmm_decode and
// assert_macros.svh.
//
// Usage:
//   req  - one CPU bus access per request: operation, 24-bit bus_address,
//          write_byte. Accepted when valid and ready are both high.
//   rsp  - one result per request, in order: target, local_offset,
//          read_byte, access_cycles.
//   cfg  - register writes (index 0 low_rom_layout, 1 save_ram_mask), always
//          ready; write only while no request is in flight.
// Timing: a request is decoded and its RAM read or write issued at the
//   accepting edge, which also registers the RAM read data; the output
//   register loads when the decode stage advances into it. One request per
//   cycle is sustained while rsp.ready stays high; the single-ported
//   RAMs serve one access per request.
// Reset: both config registers clear, then a clearing pass walks both RAMs,
//   one entry per cycle, over max(WORK_RAM_BYTES, SAVE_RAM_BYTES) addresses
//   (131072 by default), filling work RAM with 0x55 and save RAM with 0x00.
//   req.ready stays low during the pass; cfg writes are still taken.
// Stall: when rsp.ready is low the output register holds, the decode stage
//   holds behind it, and req.ready drops once both are full.
module console_bus_memory_map_decoder #(
    parameter int SAVE_RAM_BYTES = cbmm_pkg::SAVE_RAM_BYTES_DEF,
    parameter int ROM_ADDR_BITS  = cbmm_pkg::ROM_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cbmm_req_if.sink    req,
    cbmm_rsp_if.source  rsp,
    cbmm_cfg_if.sink    cfg
);
    import cbmm_pkg::*;

    `include "assert_macros.svh"

    localparam int SAVE_AW   = $clog2(SAVE_RAM_BYTES);
    localparam int CLR_DEPTH = (WORK_RAM_BYTES > SAVE_RAM_BYTES) ? WORK_RAM_BYTES
                                                                 : SAVE_RAM_BYTES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

    // Storage: one synchronous port each, read data registered.
    logic [7:0] work_ram [WORK_RAM_BYTES];
    logic [7:0] save_ram [SAVE_RAM_BYTES];

    // Configuration registers.
    logic              low_rom_layout_reg;
    logic [MASK_W-1:0] save_ram_mask_reg;

    // Clearing pass after reset.
    logic              clearing_reg;
    logic [CLR_AW-1:0] clr_addr_reg;
    logic [CLR_AW-1:0] clr_addr_next;

    // Decode stage (request accepted, RAM data arriving).
    logic                s1_valid_reg;
    logic                s1_write_reg;
    dec_t                s1_dec_reg;
    logic [7:0]          wram_rd_reg;
    logic [7:0]          sram_rd_reg;

    // Output register.
    logic                out_valid_reg;
    target_t             out_target_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [7:0]          out_byte_reg;
    logic [CYCLES_W-1:0] out_cycles_reg;

    dec_t                dec;
    logic                accept;
    logic                s1_advance;
    logic                is_write;
    logic                wram_hit;
    logic                sram_hit;
    logic [WORK_RAM_AW-1:0] wram_idx;
    logic [SAVE_AW-1:0]     sram_idx;
    logic [7:0]          s1_byte;

    cbmm_decode #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_decode (
        .operation      (req.operation),
        .bus_address    (req.bus_address),
        .low_rom_layout (low_rom_layout_reg),
        .save_ram_mask  (save_ram_mask_reg),
        .dec            (dec)
    );

    // Advance the decode stage whenever the output register is free or drains.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign accept     = req.valid && req.ready;
    assign is_write   = (req.operation == OP_WRITE);
    assign wram_hit   = accept && (dec.target == TGT_WORK_RAM);
    assign sram_hit   = accept && (dec.target == TGT_SAVE_RAM);
    assign wram_idx   = dec.offset[WORK_RAM_AW-1:0];
    assign sram_idx   = dec.offset[SAVE_AW-1:0];

    assign cfg.ready  = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_rom_layout_reg <= 1'b0;
            save_ram_mask_reg  <= '0;
        end else if (cfg.valid) begin
            case (cfg.index)
                CFG_LOW_ROM_LAYOUT: low_rom_layout_reg <= cfg.data[0];
                CFG_SAVE_RAM_MASK:  save_ram_mask_reg  <= cfg.data[MASK_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clearing pass: step one entry per cycle, drop out after the last.
    assign clr_addr_next = clr_addr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_next;
            if (clr_addr_reg == CLR_LAST)
                clearing_reg <= 1'b0;
        end
    end

    // Work RAM port: clear, write, or read for the accepted request.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            work_ram[clr_addr_reg[WORK_RAM_AW-1:0]] <= WRAM_RESET_BYTE;
        else if (wram_hit && is_write)
            work_ram[wram_idx] <= req.write_byte;
        else if (wram_hit)
            wram_rd_reg <= work_ram[wram_idx];
    end

    // Save RAM port: same scheme.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            save_ram[clr_addr_reg[SAVE_AW-1:0]] <= SRAM_RESET_BYTE;
        else if (sram_hit && is_write)
            save_ram[sram_idx] <= req.write_byte;
        else if (sram_hit)
            sram_rd_reg <= save_ram[sram_idx];
    end

    // Decode stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_write_reg <= is_write;
            s1_dec_reg   <= dec;
        end
    end

    // Pick the returned byte: RAM data on RAM reads, constant otherwise.
    always_comb
    begin
        case (s1_dec_reg.target)
            TGT_WORK_RAM: s1_byte = s1_write_reg ? OPEN_BUS_00 : wram_rd_reg;
            TGT_SAVE_RAM: s1_byte = s1_write_reg ? OPEN_BUS_00 : sram_rd_reg;
            TGT_NONE:     s1_byte = s1_dec_reg.konst;
            default:      s1_byte = OPEN_BUS_00;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance) begin
            out_target_reg <= s1_dec_reg.target;
            out_offset_reg <= s1_dec_reg.offset;
            out_byte_reg   <= s1_byte;
            out_cycles_reg <= s1_dec_reg.cycles;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.target        = out_target_reg;
    assign rsp.local_offset  = out_offset_reg;
    assign rsp.read_byte     = out_byte_reg;
    assign rsp.access_cycles = out_cycles_reg;

    // No request enters while the RAMs are being cleared.
    `ASSERT_IMPL(a_no_accept_while_clearing, clearing_reg, !req.ready)
    // A stalled decode stage keeps its request.
    `ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_reg && out_valid_reg && !rsp.ready,
                 s1_valid_reg)
    // Constant or dropped results carry no offset.
    `ASSERT_IMPL(a_none_offset_zero, rsp.valid && rsp.target == TGT_NONE,
                 rsp.local_offset == '0)
    // Device targets never return data from the block.
    `ASSERT_IMPL(a_device_byte_zero,
                 rsp.valid && (rsp.target == TGT_ROM || rsp.target == TGT_PPU ||
                 rsp.target == TGT_IO || rsp.target == TGT_JOYPAD),
                 rsp.read_byte == OPEN_BUS_00)
    // Access cost is one of the two bus speeds.
    `ASSERT_IMPL(a_cycles_legal, rsp.valid,
                 rsp.access_cycles == CYC_FAST || rsp.access_cycles == CYC_SLOW)

endmodule
